// ===== src/mf3_pkg.sv =====
// Shared types, constants and compare helpers for the 3x3 median filter.
// No dependencies; every other file of the filter imports this package.
`default_nettype none
package mf3_pkg;

	localparam int PIX_W      = 8;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_IDX_W  = 1;
	localparam int CALC_W     = 14;
	localparam int MIN_DIM    = 3;
	localparam int RESET_WIDTH  = 640;
	localparam int RESET_HEIGHT = 480;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 1'b1;

	typedef logic [PIX_W-1:0] pix_t;
	typedef pix_t [2:0] trio_t;
	typedef pix_t [8:0] win_t;

	typedef struct packed {
		logic emit;
		logic border;
		logic last;
	} pos_t;

	// Element 0 is the smallest, element 2 the largest.
	function automatic trio_t sort3(input pix_t a, input pix_t b, input pix_t c);
		pix_t  lo;
		pix_t  hi;
		trio_t res;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		if (c < lo) begin
			res = {hi, lo, c};
		end else if (c < hi) begin
			res = {hi, c, lo};
		end else begin
			res = {c, hi, lo};
		end
		return res;
	endfunction

	function automatic pix_t med3(input pix_t a, input pix_t b, input pix_t c);
		trio_t s;
		s = sort3(a, b, c);
		return s[1];
	endfunction

	function automatic pix_t max3(input pix_t a, input pix_t b, input pix_t c);
		trio_t s;
		s = sort3(a, b, c);
		return s[2];
	endfunction

	function automatic pix_t min3(input pix_t a, input pix_t b, input pix_t c);
		trio_t s;
		s = sort3(a, b, c);
		return s[0];
	endfunction

endpackage
`default_nettype wire

// ===== src/mf3_if.sv =====
// Valid/ready channel interfaces for the pixel input and the filtered output.
// Depends on mf3_pkg for the pixel type.
`default_nettype none
interface mf3_in_if import mf3_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_in;
	logic drain;

	modport source (output valid, output pixel_in, output drain, input ready);
	modport sink (input valid, input pixel_in, input drain, output ready);
endinterface

interface mf3_out_if import mf3_pkg::*; ();
	logic valid;
	logic ready;
	pix_t pixel_out;
	logic frame_end;

	modport source (output valid, output pixel_out, output frame_end, input ready);
	modport sink (input valid, input pixel_out, input frame_end, output ready);
endinterface
`default_nettype wire

// ===== src/mf3_ctrl.sv =====
// Input side of the median filter: geometry registers, raster position counters
// and the per-beat border and emit decision. Depends on mf3_pkg and mf3_if.
`default_nettype none
module mf3_ctrl import mf3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mf3_in_if.sink                     din,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	input  wire logic                  s1_ready,
	output logic                       accept,
	output logic [$clog2(MAX_WIDTH)-1:0] addr,
	output pix_t                       px,
	output pos_t                       pos
);

	localparam int AW = $clog2(MAX_WIDTH);
	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_HEIGHT + 1);
	localparam int RW = $clog2(MAX_HEIGHT + 3);
	localparam int W_RST = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
	localparam int H_RST = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;

	logic [WW-1:0] width_q;
	logic [HW-1:0] height_q;
	logic [AW-1:0] col_q;
	logic [RW-1:0] row_q;

	logic [CALC_W-1:0] cfg_c;
	logic [WW-1:0]     width_new;
	logic [HW-1:0]     height_new;
	logic [CALC_W-1:0] col_c;
	logic [CALC_W-1:0] row_c;
	logic [CALC_W-1:0] w_c;
	logic [CALC_W-1:0] h_c;
	logic [CALC_W-1:0] oc;
	logic [CALC_W-1:0] orow;
	logic              row_last;
	logic              col_last;

	assign din.ready = s1_ready;
	assign accept    = din.valid && s1_ready;
	assign addr      = col_q;
	assign px        = din.drain ? '0 : din.pixel_in;

	always_comb begin
		cfg_c = CALC_W'(cfg_data);
		if (cfg_c < CALC_W'(MIN_DIM)) begin
			width_new  = WW'(MIN_DIM);
			height_new = HW'(MIN_DIM);
		end else begin
			width_new  = (cfg_c > CALC_W'(MAX_WIDTH)) ? WW'(MAX_WIDTH) : WW'(cfg_c);
			height_new = (cfg_c > CALC_W'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(cfg_c);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WW'(W_RST);
			height_q <= HW'(H_RST);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH:  width_q  <= width_new;
				REG_IMAGE_HEIGHT: height_q <= height_new;
				default: ;
			endcase
		end
	end

	always_comb begin
		col_c = CALC_W'(col_q);
		row_c = CALC_W'(row_q);
		w_c   = CALC_W'(width_q);
		h_c   = CALC_W'(height_q);
		pos.emit = (row_c >= CALC_W'(2)) || (row_c == CALC_W'(1) && col_c != '0);
		if (col_c == '0) begin
			oc   = w_c - CALC_W'(1);
			orow = row_c - CALC_W'(2);
		end else begin
			oc   = col_c - CALC_W'(1);
			orow = row_c - CALC_W'(1);
		end
		row_last   = orow >= h_c - CALC_W'(1);
		col_last   = oc >= w_c - CALC_W'(1);
		pos.border = (orow == '0) || row_last || (oc == '0) || col_last;
		pos.last   = pos.emit && row_last && col_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (pos.last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (col_c + CALC_W'(1) >= w_c) begin
				col_q <= '0;
				if (row_q != '1) begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_q + AW'(1);
			end
		end
	end

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pos.last) |=> (col_q == '0 && row_q == '0))
		else $error("position counters did not restart after the last beat of a frame");

endmodule
`default_nettype wire

// ===== src/mf3_line_store.sv =====
// Two line memories with registered reads, write-back forwarding and the 3x3
// window register. Depends on mf3_pkg.
`default_nettype none
module mf3_line_store import mf3_pkg::*; #(
	parameter int MAX_WIDTH = 1024
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         accept,
	input  wire logic [$clog2(MAX_WIDTH)-1:0] addr,
	input  wire pix_t                         px,
	input  wire pos_t                         pos,
	input  wire logic                         s2_ready,
	output logic                              s1_ready,
	output logic                              push,
	output win_t                              win,
	output pos_t                              push_pos
);

	localparam int AW = $clog2(MAX_WIDTH);

	pix_t up_mem  [MAX_WIDTH];
	pix_t mid_mem [MAX_WIDTH];

	logic          v_s1;
	logic [AW-1:0] addr_s1;
	pix_t          px_s1;
	pos_t          pos_s1;
	pix_t          up_rd_s1;
	pix_t          mid_rd_s1;
	logic          fwd_s1;
	pix_t          fwd_up_s1;
	pix_t          fwd_mid_s1;

	pix_t win_q [3][3];

	logic adv1;
	pix_t up_eff;
	pix_t mid_eff;

	assign adv1     = v_s1 && (!pos_s1.emit || s2_ready);
	assign s1_ready = !v_s1 || adv1;
	assign up_eff   = fwd_s1 ? fwd_up_s1 : up_rd_s1;
	assign mid_eff  = fwd_s1 ? fwd_mid_s1 : mid_rd_s1;
	assign push     = adv1 && pos_s1.emit;
	assign push_pos = pos_s1;

	always_ff @(posedge clk) begin
		if (adv1) begin
			up_mem[addr_s1]  <= mid_eff;
			mid_mem[addr_s1] <= px_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			up_rd_s1   <= up_mem[addr];
			mid_rd_s1  <= mid_mem[addr];
			addr_s1    <= addr;
			px_s1      <= px;
			pos_s1     <= pos;
			fwd_up_s1  <= mid_eff;
			fwd_mid_s1 <= px_s1;
		end
	end

	// The beat in flight writes the entry at the same edge that a new beat reads it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v_s1   <= 1'b1;
				fwd_s1 <= adv1 && (addr_s1 == addr);
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
		end
	end

	always_comb begin
		for (int r = 0; r < 3; r++) begin
			win[r*3]     = win_q[r][1];
			win[r*3 + 1] = win_q[r][2];
		end
		win[2] = up_eff;
		win[5] = mid_eff;
		win[8] = px_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= '0;
				end
			end
		end else if (adv1) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					win_q[r][c] <= win[r*3 + c];
				end
			end
		end
	end

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && v_s1) |-> adv1)
		else $error("new beat accepted over a stalled beat");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> v_s1)
		else $error("accepted beat missing from the read stage");

endmodule
`default_nettype wire

// ===== src/mf3_median.sv =====
// Two-stage median network (column sort, then rank select) and the output
// register. Depends on mf3_pkg and mf3_if.
`default_nettype none
module mf3_median import mf3_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire win_t win,
	input  wire pos_t push_pos,
	output logic      s2_ready,
	mf3_out_if.source dout
);

	logic  v_s2;
	trio_t cols_s2 [3];
	pix_t  center_s2;
	logic  border_s2;
	logic  last_s2;

	logic out_v_q;
	pix_t pix_q;
	logic end_q;

	logic adv2;
	pix_t low;
	pix_t mid;
	pix_t high;
	pix_t med;

	assign adv2     = v_s2 && (!out_v_q || dout.ready);
	assign s2_ready = !v_s2 || adv2;

	always_ff @(posedge clk) begin
		if (push) begin
			for (int c = 0; c < 3; c++) begin
				cols_s2[c] <= sort3(win[c], win[3 + c], win[6 + c]);
			end
			center_s2 <= win[4];
			border_s2 <= push_pos.border;
			last_s2   <= push_pos.last;
		end
	end

	always_comb begin
		low  = max3(cols_s2[0][0], cols_s2[1][0], cols_s2[2][0]);
		mid  = med3(cols_s2[0][1], cols_s2[1][1], cols_s2[2][1]);
		high = min3(cols_s2[0][2], cols_s2[1][2], cols_s2[2][2]);
		med  = med3(low, mid, high);
	end

	always_ff @(posedge clk) begin
		if (adv2) begin
			pix_q <= border_s2 ? center_s2 : med;
			end_q <= last_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (push) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2) begin
				out_v_q <= 1'b1;
			end else if (dout.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign dout.valid     = out_v_q;
	assign dout.pixel_out = pix_q;
	assign dout.frame_end = end_q;

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> s2_ready)
		else $error("window pushed into a full sort stage");

endmodule
`default_nettype wire

// ===== src/median_filter_3x3.sv =====
// Streaming 3x3 median filter for 8-bit grayscale pixels in raster order. It takes
// one pixel beat per clock unless the output stalls it and gives at most one result
// beat per clock. A beat passes through a line-memory read stage, a column-sort stage
// and the output register; a result is offered there once the beat completing its
// window has passed the first two, and that beat comes one line plus one pixel after
// its own pixel. A held-off output stalls the input once the three stages are full.
// The single read and write port of each line memory is what sets the rate of one
// beat per cycle. Frame border pixels are passed unchanged. After the last pixel of
// a frame, send image_width+1 drain beats to flush the tail; the beat after the last
// drain beat starts the next frame. No memory clearing is needed after reset. Depends on
// mf3_pkg, mf3_if, mf3_ctrl, mf3_line_store and mf3_median.
`default_nettype none
module median_filter_3x3 import mf3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	mf3_in_if.sink                     din,
	mf3_out_if.source                  dout,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW = $clog2(MAX_WIDTH);

	logic          accept;
	logic [AW-1:0] addr;
	pix_t          px;
	pos_t          pos;
	logic          s1_ready;
	logic          s2_ready;
	logic          push;
	win_t          win;
	pos_t          push_pos;

	mf3_ctrl #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.din       (din),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s1_ready  (s1_ready),
		.accept    (accept),
		.addr      (addr),
		.px        (px),
		.pos       (pos)
	);

	mf3_line_store #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_line_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.addr     (addr),
		.px       (px),
		.pos      (pos),
		.s2_ready (s2_ready),
		.s1_ready (s1_ready),
		.push     (push),
		.win      (win),
		.push_pos (push_pos)
	);

	mf3_median u_median (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.win      (win),
		.push_pos (push_pos),
		.s2_ready (s2_ready),
		.dout     (dout)
	);

endmodule
`default_nettype wire

// ===== verif/median_filter_3x3_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the 3x3 median filter: it follows the pixel stream and the register writes,
// keeps its own line memories and window, and compares every output beat with the prediction.
// Depends on mf3_pkg and the channel interfaces in mf3_if.
module median_filter_3x3_checker import mf3_pkg::*; #(
	parameter int MAX_WIDTH  = 1024,
	parameter int MAX_HEIGHT = 1024
) (
	input  logic                  clk,
	input  logic                  arst_n,
	mf3_in_if                     din,
	mf3_out_if                    dout,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output int unsigned           fail_count,
	output int unsigned           outstanding
);

	typedef struct packed {
		pix_t pixel;
		logic frame_end;
	} filtered_t;

	int unsigned frame_width;
	int unsigned frame_height;
	pix_t        upper_line [MAX_WIDTH];
	pix_t        middle_line [MAX_WIDTH];
	pix_t        window [3][3];
	int unsigned col_pos;
	int unsigned row_pos;
	filtered_t   awaited_pixels [$];
	int unsigned errs;

	function automatic int unsigned clamp_dim(input logic [CFG_DATA_W-1:0] v,
			input int unsigned maxv);
		if (v < MIN_DIM) begin
			return MIN_DIM;
		end
		if (v > maxv) begin
			return maxv;
		end
		return v;
	endfunction

	function automatic pix_t window_median();
		pix_t v [9];
		pix_t t;
		for (int i = 0; i < 9; i++) begin
			v[i] = window[i / 3][i % 3];
		end
		for (int i = 0; i < 8; i++) begin
			for (int j = 0; j < 8 - i; j++) begin
				if (v[j] > v[j + 1]) begin
					t = v[j];
					v[j] = v[j + 1];
					v[j + 1] = t;
				end
			end
		end
		return v[4];
	endfunction

	// One accepted beat: shift the window, update the line memories, and queue the result
	// that this beat completes, if any.
	function automatic void slide_window(input pix_t px_raw, input logic is_drain);
		int unsigned col, row, idx, oc, orow, w, h;
		pix_t px, up, mid, val;
		logic emit, last;
		filtered_t next_result;
		w = frame_width;
		h = frame_height;
		col = col_pos;
		row = row_pos;
		idx = (col < MAX_WIDTH) ? col : MAX_WIDTH - 1;
		px = is_drain ? '0 : px_raw;
		up = upper_line[idx];
		mid = middle_line[idx];
		upper_line[idx] = mid;
		middle_line[idx] = px;
		for (int r = 0; r < 3; r++) begin
			window[r][0] = window[r][1];
			window[r][1] = window[r][2];
		end
		window[0][2] = up;
		window[1][2] = mid;
		window[2][2] = px;
		emit = (row >= 2) || (row == 1 && col >= 1);
		last = 1'b0;
		if (emit) begin
			if (col == 0) begin
				oc = w - 1;
				orow = row - 2;
			end else begin
				oc = col - 1;
				orow = row - 1;
			end
			if (orow == 0 || orow >= h - 1 || oc == 0 || oc >= w - 1) begin
				val = window[1][1];
			end else begin
				val = window_median();
			end
			last = (orow >= h - 1) && (oc >= w - 1);
			next_result = '{pixel: val, frame_end: last};
			awaited_pixels = {awaited_pixels, next_result};
		end
		if (last) begin
			col_pos = 0;
			row_pos = 0;
		end else if (col + 1 >= w) begin
			col_pos = 0;
			if (row < 32'hFFFF) begin
				row_pos = row + 1;
			end
		end else begin
			col_pos = col + 1;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filtered_t got;
		filtered_t want;
		if (!arst_n) begin
			frame_width = RESET_WIDTH;
			frame_height = RESET_HEIGHT;
			for (int i = 0; i < MAX_WIDTH; i++) begin
				upper_line[i] = '0;
				middle_line[i] = '0;
			end
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					window[r][c] = '0;
				end
			end
			col_pos = 0;
			row_pos = 0;
			awaited_pixels.delete();
			errs = 0;
			fail_count <= 0;
			outstanding <= 0;
		end else begin
			if (dout.valid && dout.ready) begin
				got = '{pixel: dout.pixel_out, frame_end: dout.frame_end};
				if (awaited_pixels.size() == 0) begin
					errs++;
					$error("output beat with nothing expected: pixel_out %0d, frame_end %0b",
						got.pixel, got.frame_end);
				end else begin
					want = awaited_pixels.pop_front();
					if (got.pixel !== want.pixel) begin
						errs++;
						$error("pixel_out: expected %0d, actual %0d", want.pixel, got.pixel);
					end
					if (got.frame_end !== want.frame_end) begin
						errs++;
						$error("frame_end: expected %0b, actual %0b",
							want.frame_end, got.frame_end);
					end
				end
			end
			if (din.valid && din.ready) begin
				slide_window(din.pixel_in, din.drain);
			end
			if (cfg_we) begin
				case (cfg_index)
					REG_IMAGE_WIDTH: begin
						frame_width = clamp_dim(cfg_data, MAX_WIDTH);
					end
					REG_IMAGE_HEIGHT: begin
						frame_height = clamp_dim(cfg_data, MAX_HEIGHT);
					end
					default: begin
					end
				endcase
			end
			fail_count <= errs;
			outstanding <= awaited_pixels.size();
		end
	end

endmodule

// ===== verif/median_filter_3x3_tb.sv =====
`timescale 1ns / 100ps
// Top of the median filter testbench: clock, reset, register writes and pixel frames with
// random gaps and stalls on both channels; the checker instance does all the comparing.
// Depends on mf3_pkg, mf3_if, median_filter_3x3 and median_filter_3x3_checker.
module median_filter_3x3_tb;
	import mf3_pkg::*;

	localparam int          MAX_WIDTH    = 1024;
	localparam int          MAX_HEIGHT   = 1024;
	localparam int unsigned RANDOM_ITEMS = 350;
	localparam int unsigned MAX_GAP      = 13;
	localparam int unsigned HOLD_CYCLES  = 600;
	localparam int unsigned SETTLE       = 8;
	localparam int unsigned TIMEOUT_NS   = 1_500_000;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int unsigned           fail_count;
	int unsigned           outstanding;
	bit                    idle_on = 1'b1;
	bit                    hold_req = 1'b0;

	mf3_in_if  in_ch ();
	mf3_out_if out_ch ();

	median_filter_3x3 #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	median_filter_3x3_checker #(
		.MAX_WIDTH(MAX_WIDTH),
		.MAX_HEIGHT(MAX_HEIGHT)
	) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.din(in_ch),
		.dout(out_ch),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.fail_count(fail_count),
		.outstanding(outstanding)
	);

	always #4 clk = ~clk;

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// Output side: random stall before each beat while idle_on is set, plus one long hold-off on request.
	initial begin
		int unsigned stall;
		bit held;
		held = 1'b0;
		out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_req && !held) begin
				held = 1'b1;
				out_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = idle_on ? $urandom_range(0, MAX_GAP) : 0;
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	task automatic send_beat(input pix_t px, input logic is_drain);
		int unsigned gap;
		gap = idle_on ? $urandom_range(0, MAX_GAP) : 0;
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.pixel_in <= px;
		in_ch.drain <= is_drain;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic wait_drained();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic program_geometry(input logic [CFG_DATA_W-1:0] w,
			input logic [CFG_DATA_W-1:0] h);
		cfg_we <= 1'b1;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_index <= REG_IMAGE_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// A whole frame followed by its flush beats; noise swaps pixel and drain beats.
	task automatic send_frame(input int unsigned w, input int unsigned h,
			input int unsigned style, input int unsigned noise_pct, input bit pause_mid);
		int unsigned total;
		pix_t px;
		logic is_drain;
		total = w * h + w + 1;
		for (int unsigned n = 0; n < total; n++) begin
			case (style)
				0: px = $urandom_range(0, 255);
				1: px = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				2: px = pix_t'(n * 7 + $urandom_range(0, 15));
				default: begin
					case ($urandom_range(0, 4))
						0: px = 8'h00;
						1: px = 8'h01;
						2: px = 8'h80;
						3: px = 8'hFE;
						default: px = 8'hFF;
					endcase
				end
			endcase
			is_drain = (n >= w * h);
			if ($urandom_range(0, 99) < noise_pct) begin
				is_drain = ~is_drain;
			end
			if (pause_mid && n == total / 2) begin
				wait_drained();
			end
			send_beat(px, is_drain);
		end
	endtask

	initial begin
		int unsigned w_raw, h_raw, w, h, random_sent;
		bit paused;
		in_ch.valid <= 1'b0;
		in_ch.pixel_in <= '0;
		in_ch.drain <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= REG_IMAGE_WIDTH;
		cfg_data <= '0;
		arst_n <= 1'b0;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Both registers below the minimum, so a 3x3 frame. The first frame alternates black
		// and white, drains included; the second has a drain as its center pixel and a
		// pixel where a flush beat is due.
		program_geometry(0, 1);
		for (int n = 0; n < 13; n++) begin
			send_beat((n % 2) ? 8'hFF : 8'h00, n >= 9);
		end
		for (int n = 0; n < 13; n++) begin
			send_beat((n % 2) ? 8'h00 : 8'hFF, (n >= 9) != (n == 4 || n == 10));
		end
		wait_drained();

		// Wide lines with no gaps while the output side holds off, so the input backs up.
		idle_on = 1'b0;
		hold_req = 1'b1;
		program_geometry(40, 2);
		send_frame(40, 3, 0, 0, 1'b0);
		wait_drained();

		idle_on = 1'b1;
		program_geometry(3, 60);
		send_frame(3, 60, 1, 2, 1'b0);
		wait_drained();
		program_geometry(33, 4);
		send_frame(33, 4, 2, 0, 1'b0);
		wait_drained();

		random_sent = 0;
		paused = 1'b0;
		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: w_raw = $urandom_range(0, 2);
				1, 2: w_raw = $urandom_range(17, 40);
				default: w_raw = $urandom_range(3, 16);
			endcase
			case ($urandom_range(0, 9))
				0: h_raw = $urandom_range(0, 2);
				1: h_raw = $urandom_range(11, 16);
				default: h_raw = $urandom_range(3, 10);
			endcase
			w = (w_raw < MIN_DIM) ? MIN_DIM : w_raw;
			h = (h_raw < MIN_DIM) ? MIN_DIM : h_raw;
			idle_on = ($urandom_range(0, 3) != 0);
			program_geometry(w_raw, h_raw);
			repeat ($urandom_range(1, 3)) begin
				send_frame(w, h, $urandom_range(0, 3),
					($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 0, !paused);
				paused = 1'b1;
				random_sent += w * h + w + 1;
			end
			wait_drained();
		end

		if (fail_count == 0 && outstanding == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
src/mf3_pkg.sv
src/mf3_if.sv
src/mf3_ctrl.sv
src/mf3_line_store.sv
src/mf3_median.sv
src/median_filter_3x3.sv
verif/median_filter_3x3_checker.sv
verif/median_filter_3x3_tb.sv
